// ----- design/cbp_pkg.sv -----
// Shared types, constants and helpers for the COMPAX bitmap-to-positions decoder.
package cbp_pkg;

   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned GROUP_BITS = 31;
   localparam int unsigned COUNT_BITS = 29;
   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned INDEX_BITS = 5;

   localparam logic [WORD_BITS-1:0] POS_MAX = '1;

   // Flag codes in bits 30..29 of a non-literal word
   localparam logic [1:0] FLAGS_ZERO_FILL = 2'b00;
   localparam logic [1:0] FLAGS_LFL       = 2'b01;
   localparam logic [1:0] FLAGS_FLF       = 2'b10;
   localparam logic [1:0] FLAGS_FLF_ALT   = 2'b11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_A,
      ST_LIT_A,
      ST_FILL_B,
      ST_LIT_B
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // capture a new word
      logic fill_a;    // advance by the first fill count
      logic fill_b;    // advance by the second fill count, stage literal B
      logic lit_step;  // one literal step: emit lowest bit and/or advance a group
      logic phase_b;   // literal step belongs to literal B
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic has_la;
      logic has_fb;
      logic has_lb;
      logic lit_empty;   // no set bit left in the current literal
      logic lit_single;  // at most one set bit left
      logic out_free;    // output register can take a beat this cycle
   } sts_type;

   // Byte literal placed at a byte offset inside a 31-bit group; bit 31 drops out
   function automatic logic [GROUP_BITS-1:0] placed_lit(logic [BYTE_BITS-1:0] lit_byte,
                                                        logic [1:0] offset);
      logic [WORD_BITS-1:0] shifted;
      shifted = {{(WORD_BITS-BYTE_BITS){1'b0}}, lit_byte} << {offset, 3'b000};
      return shifted[GROUP_BITS-1:0];
   endfunction

endpackage

// ----- design/cbp_ctrl.sv -----
// Sequencing state machine: walks each word through its fill and literal segments.
module cbp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  cbp_pkg::sts_type sts,
   output cbp_pkg::cmd_type cmd
);
   import cbp_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_FILL_A;
            end
         end
         ST_FILL_A: begin
            cmd.fill_a = 1'b1;
            state_in   = sts.has_la ? ST_LIT_A : ST_IDLE;
         end
         ST_LIT_A: begin
            // an empty literal only advances, so it needs no output slot
            cmd.lit_step = sts.lit_empty || sts.out_free;
            if (cmd.lit_step && sts.lit_single) begin
               state_in = sts.has_fb ? ST_FILL_B : ST_IDLE;
            end
         end
         ST_FILL_B: begin
            cmd.fill_b = 1'b1;
            state_in   = sts.has_lb ? ST_LIT_B : ST_IDLE;
         end
         ST_LIT_B: begin
            cmd.phase_b  = 1'b1;
            cmd.lit_step = sts.lit_empty || sts.out_free;
            if (cmd.lit_step && sts.lit_single) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/cbp_datapath.sv -----
// Word decode, running position, bit search and output register.
module cbp_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [cbp_pkg::WORD_BITS-1:0]    code_word,
   input  logic                             first_word,
   input  cbp_pkg::cmd_type                 cmd,
   output cbp_pkg::sts_type                 sts,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cbp_pkg::WORD_BITS-1:0]    rsp_position,
   output logic                             rsp_last,
   output logic                             rsp_overflow
);
   import cbp_pkg::*;

   // Decoded segments of the current word
   logic [COUNT_BITS-1:0] fa_ff, fa_in;
   logic [BYTE_BITS-1:0]  fb_ff, fb_in;
   logic [GROUP_BITS-1:0] la_in;
   logic [GROUP_BITS-1:0] lb_ff, lb_in;
   logic                  has_la_ff, has_la_in;
   logic                  has_fb_ff, has_fb_in;
   logic                  has_lb_ff, has_lb_in;

   // Running state and remaining literal bits
   logic [WORD_BITS-1:0]  rp_ff, rp_in;
   logic                  ovf_ff, ovf_in;
   logic [GROUP_BITS-1:0] rem_ff, rem_in;

   // Output register
   logic                  valid_ff, valid_in;
   logic [WORD_BITS-1:0]  pos_ff, pos_in;
   logic                  last_ff, last_in;
   logic                  oflag_ff, oflag_in;

   logic [COUNT_BITS-1:0]   grp;
   logic [COUNT_BITS+5:0]   adv_amt;
   logic [COUNT_BITS+5:0]   adv_sum;
   logic                    adv_ovf;
   logic                    advance_now;
   logic [INDEX_BITS-1:0]   idx;
   logic [GROUP_BITS-1:0]   rem_clr;
   logic [WORD_BITS:0]      emit_sum;
   logic                    emit_ovf;
   logic                    emit;
   logic                    out_free;

   // Word decode into fill A, literal A, fill B, literal B
   always_comb begin
      fa_in     = '0;
      fb_in     = '0;
      la_in     = '0;
      lb_in     = '0;
      has_la_in = 1'b0;
      has_fb_in = 1'b0;
      has_lb_in = 1'b0;
      if (code_word[WORD_BITS-1]) begin
         la_in     = code_word[GROUP_BITS-1:0];
         has_la_in = 1'b1;
      end else begin
         case (code_word[30:29]) inside
            FLAGS_ZERO_FILL: begin
               fa_in = code_word[COUNT_BITS-1:0];
            end
            FLAGS_LFL: begin
               la_in     = placed_lit(code_word[23:16], code_word[28:27]);
               fb_in     = code_word[15:8];
               lb_in     = placed_lit(code_word[7:0], code_word[26:25]);
               has_la_in = 1'b1;
               has_fb_in = 1'b1;
               has_lb_in = 1'b1;
            end
            FLAGS_FLF, FLAGS_FLF_ALT: begin
               fa_in     = {{(COUNT_BITS-BYTE_BITS){1'b0}}, code_word[23:16]};
               la_in     = placed_lit(code_word[15:8], code_word[28:27]);
               fb_in     = code_word[7:0];
               has_la_in = 1'b1;
               has_fb_in = 1'b1;
            end
         endcase
      end
   end

   // Advance by groups * 31 with saturation
   always_comb begin
      if (cmd.fill_a) begin
         grp = fa_ff;
      end else if (cmd.fill_b) begin
         grp = {{(COUNT_BITS-BYTE_BITS){1'b0}}, fb_ff};
      end else begin
         grp = COUNT_BITS'(1);
      end
      adv_amt = {1'b0, grp, 5'b00000} - {6'b000000, grp};
      adv_sum = {3'b000, rp_ff} + adv_amt;
      adv_ovf = (adv_sum[COUNT_BITS+5:WORD_BITS] != '0);
   end

   // Lowest set bit of the remaining literal
   always_comb begin
      idx = '0;
      for (int k = GROUP_BITS - 1; k >= 0; k--) begin
         if (rem_ff[k]) begin
            idx = INDEX_BITS'(k);
         end
      end
      rem_clr  = rem_ff & (rem_ff - GROUP_BITS'(1));
      emit_sum = {1'b0, rp_ff} + {{(WORD_BITS+1-INDEX_BITS){1'b0}}, idx};
      emit_ovf = emit_sum[WORD_BITS];
   end

   assign out_free    = !valid_ff || rsp_ready;
   assign emit        = cmd.lit_step && (rem_ff != '0);
   assign advance_now = cmd.fill_a || cmd.fill_b || (cmd.lit_step && (rem_clr == '0));

   // Running position, overflow and literal bits
   always_comb begin
      rp_in  = rp_ff;
      ovf_in = ovf_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         if (first_word) begin
            rp_in  = '0;
            ovf_in = 1'b0;
         end
         rem_in = la_in;
      end else begin
         if (advance_now) begin
            rp_in = adv_ovf ? POS_MAX : adv_sum[WORD_BITS-1:0];
         end
         ovf_in = ovf_ff | (emit && emit_ovf) | (advance_now && adv_ovf);
         if (cmd.fill_b) begin
            rem_in = lb_ff;
         end else if (emit) begin
            rem_in = rem_clr;
         end
      end
   end

   // Output beat formation
   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      pos_in   = pos_ff;
      last_in  = last_ff;
      oflag_in = oflag_ff;
      if (emit) begin
         valid_in = 1'b1;
         pos_in   = emit_ovf ? POS_MAX : emit_sum[WORD_BITS-1:0];
         last_in  = (rem_clr == '0) && (cmd.phase_b || (lb_ff == '0));
         oflag_in = ovf_ff | emit_ovf;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff    <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         rp_ff    <= rp_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      pos_ff   <= pos_in;
      last_ff  <= last_in;
      oflag_ff <= oflag_in;
      if (cmd.load) begin
         fa_ff     <= fa_in;
         fb_ff     <= fb_in;
         lb_ff     <= lb_in;
         has_la_ff <= has_la_in;
         has_fb_ff <= has_fb_in;
         has_lb_ff <= has_lb_in;
      end
   end

   assign sts.has_la     = has_la_ff;
   assign sts.has_fb     = has_fb_ff;
   assign sts.has_lb     = has_lb_ff;
   assign sts.lit_empty  = (rem_ff == '0);
   assign sts.lit_single = (rem_clr == '0);
   assign sts.out_free   = out_free;

   assign rsp_valid    = valid_ff;
   assign rsp_position = pos_ff;
   assign rsp_last     = last_ff;
   assign rsp_overflow = oflag_ff;

endmodule

// ----- design/compax_bitmap_to_positions_core.sv -----
// Top level of the COMPAX bitmap-to-positions decoder.
// Usage:
//   req channel: one COMPAX code word per beat in req_tdata, req_tuser[0] set on the
//   first word of a bitmap (restarts the running position at 0 and clears overflow).
//   rsp channel: one beat per set bit, ascending; rsp_tdata is the bit position,
//   rsp_tlast marks the last position of a word, rsp_tuser[0] is the sticky overflow.
//   A word that encodes no set bit produces no beat.
// Timing: a word is taken in the idle state; the sequencer then passes the leading fill
//   state for every word, one literal step per set bit of each literal (one step for an
//   empty literal) and the second fill state. A zero fill visits idle and fill A only;
//   a literal word adds literal A, an FLF word adds literal A and fill B, and an LFL
//   word visits every state. The priority search over the literal bits emits one
//   position per cycle while the output register is free, so the set-bit count sets
//   the pace. The first position leaves in the cycle after its literal step starts.
// Reset: synchronous; clears the running position, overflow and output register.
// Stall: the output register holds one beat; while rsp_tready is low and that beat
//   waits, emitting literal steps pause. Empty steps, fills and word intake go on.
module compax_bitmap_to_positions_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] code_word
   input  logic [0:0]  req_tuser,   // [0] first_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] position
   output logic        rsp_tlast,   // last_of_word
   output logic [0:0]  rsp_tuser    // [0] overflow
);
   import cbp_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    rsp_overflow;

   // Sequencer
   cbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath
   cbp_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .code_word    (req_tdata),
      .first_word   (req_tuser[0]),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_position (rsp_tdata),
      .rsp_last     (rsp_tlast),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_tuser = rsp_overflow;

   // A bit is emitted only when the output register can take it
   a_emit_has_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.lit_step && !sts.lit_empty) |-> sts.out_free)
      else $error("literal step emitted into an occupied output register");

   // An emitted bit shows up as a beat on the next cycle
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.lit_step && !sts.lit_empty) |=> rsp_tvalid)
      else $error("emitted position missing on rsp channel");

   // The block is busy right after taking a word
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("word intake while previous word still decoding");

endmodule

// ----- verif/compax_bitmap_to_positions_core_tb.sv -----
// Self-checking testbench for the COMPAX bitmap-to-positions decoder core.
module compax_bitmap_to_positions_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cbp_pkg::*;

   localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no beat on either side
   localparam int unsigned TAIL_CYCLES  = 50;
   localparam int unsigned RANDOM_WORDS = 338;

   // One expected output beat
   typedef struct packed {
      logic [31:0] position;
      logic        last;
      logic        ovf;
   } pos_beat_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] code_word
   logic [0:0]  req_tuser;   // [0] first_word
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] position
   logic        rsp_tlast;   // last_of_word
   logic [0:0]  rsp_tuser;   // [0] overflow

   // Predictor state
   logic [31:0]  run_pos;
   logic         ovf_seen;
   pos_beat_type word_beats [0:30];
   int           word_count;
   pos_beat_type pending_positions [$];

   int errors;
   bit no_idle;

   compax_bitmap_to_positions_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // Clamp to 32 bits, latching the sticky overflow
   function automatic logic [31:0] saturate(input logic [63:0] v);
      if (v > 64'h0000_0000_FFFF_FFFF) begin
         ovf_seen = 1'b1;
         return '1;
      end
      return v[31:0];
   endfunction

   function automatic logic [30:0] place_byte(input logic [7:0] b, input logic [1:0] off);
      logic [31:0] shifted;
      shifted = {24'd0, b} << (off * 8);
      return shifted[30:0];   // top bit of offset 3 falls out of the group
   endfunction

   task automatic advance_groups(input logic [63:0] groups);
      run_pos = saturate({32'd0, run_pos} + groups * 64'd31);
   endtask

   // Positions of the set bits of one 31-bit group, then step past the group
   task automatic emit_group(input logic [30:0] bits);
      pos_beat_type b;
      for (int i = 0; i < 31; i++) begin
         if (bits[i]) begin
            b.position = saturate({32'd0, run_pos} + i);
            b.last     = 1'b0;
            b.ovf      = ovf_seen;
            word_beats[word_count] = b;
            word_count++;
         end
      end
      advance_groups(64'd1);
   endtask

   task automatic decode_word(input logic [31:0] w, input logic first);
      if (first) begin
         run_pos  = '0;
         ovf_seen = 1'b0;
      end
      word_count = 0;
      if (w[31]) begin
         emit_group(w[30:0]);
      end else begin
         case (w[30:29])
            FLAGS_ZERO_FILL: begin
               advance_groups({35'd0, w[28:0]});
            end
            FLAGS_LFL: begin
               emit_group(place_byte(w[23:16], w[28:27]));
               advance_groups({56'd0, w[15:8]});
               emit_group(place_byte(w[7:0], w[26:25]));
            end
            FLAGS_FLF, FLAGS_FLF_ALT: begin
               advance_groups({56'd0, w[23:16]});
               emit_group(place_byte(w[15:8], w[28:27]));
               advance_groups({56'd0, w[7:0]});
            end
         endcase
      end
      if (word_count > 0) word_beats[word_count-1].last = 1'b1;
      for (int i = 0; i < word_count; i++)
         pending_positions.insert(pending_positions.size(), word_beats[i]);
   endtask

   // ---------------------------------------------------------------- driving

   // Send one code word; valid stays high when the next word follows at once
   task automatic send_word(input logic [31:0] w, input logic first);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      decode_word(w, first);
   endtask

   function automatic logic [31:0] lfl_word(input logic [1:0] off_a, input logic [1:0] off_b,
                                            input logic [7:0] lit_a, input logic [7:0] fill,
                                            input logic [7:0] lit_b);
      return {1'b0, FLAGS_LFL, off_a, off_b, 1'b0, lit_a, fill, lit_b};
   endfunction

   function automatic logic [31:0] flf_word(input logic [1:0] flags, input logic [1:0] off,
                                            input logic [7:0] fill_a, input logic [7:0] lit,
                                            input logic [7:0] fill_b);
      // bits 26..24 are don't-care; set them to show they are ignored
      return {1'b0, flags, off, 3'b101, fill_a, lit, fill_b};
   endfunction

   // Receiver: random hold-off before each beat
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      pos_beat_type exp_beat;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_positions.size() == 0) begin
            $display("%0t: unexpected beat, position %h last %b overflow %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser[0]);
            errors++;
         end else begin
            exp_beat = pending_positions.pop_front();
            if (rsp_tdata !== exp_beat.position) begin
               $display("%0t: position mismatch, expected %h actual %h",
                        $time, exp_beat.position, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== exp_beat.last) begin
               $display("%0t: last_of_word mismatch, expected %b actual %b",
                        $time, exp_beat.last, rsp_tlast);
               errors++;
            end
            if (rsp_tuser[0] !== exp_beat.ovf) begin
               $display("%0t: overflow mismatch, expected %b actual %b",
                        $time, exp_beat.ovf, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   // Watchdog: ends the run if no beat moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   task automatic test_literals();
      send_word(32'hFFFF_FFFF, 1'b1);   // all 31 bits set
      send_word(32'h8000_0000, 1'b0);   // empty literal still advances
      send_word(32'hC000_0001, 1'b0);   // lowest and highest group bit
      send_word(32'h8000_0001, 1'b0);
   endtask

   task automatic test_zero_fills();
      send_word(32'h0000_0000, 1'b0);   // zero count
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h8000_0002, 1'b0);
      send_word(32'h0000_0005, 1'b1);   // restart on a fill
      send_word(32'h8000_0004, 1'b0);
   endtask

   task automatic test_lfl();
      send_word(lfl_word(2'd0, 2'd3, 8'hFF, 8'h00, 8'hFF), 1'b0);
      send_word(lfl_word(2'd3, 2'd0, 8'h81, 8'hFF, 8'h01), 1'b0);
      send_word(lfl_word(2'd1, 2'd2, 8'h00, 8'h07, 8'h00), 1'b0);  // both literals empty
      send_word(lfl_word(2'd1, 2'd2, 8'h0F, 8'h10, 8'hF0), 1'b0);
   endtask

   task automatic test_flf();
      send_word(flf_word(FLAGS_FLF, 2'd3, 8'hFF, 8'hFF, 8'hFF), 1'b0);
      send_word(flf_word(FLAGS_FLF_ALT, 2'd2, 8'h03, 8'h00, 8'h04), 1'b0);  // empty literal
      send_word(flf_word(FLAGS_FLF_ALT, 2'd0, 8'h00, 8'h01, 8'h00), 1'b0);
   endtask

   task automatic test_overflow();
      // 138547332 groups put the position at 0xFFFFFFFC
      send_word(32'd138547332, 1'b1);
      send_word(32'h8000_001F, 1'b0);   // overflow rises inside the word
      send_word(32'h8000_0001, 1'b0);   // saturated and sticky
      send_word(32'h1FFF_FFFF, 1'b1);   // fill alone overflows
      send_word(flf_word(FLAGS_FLF, 2'd1, 8'h01, 8'h10, 8'h01), 1'b0);
      send_word(32'h8000_0001, 1'b1);   // restart clears the flag
   endtask

   function automatic logic [31:0] random_word();
      logic [31:0] r;
      logic [31:0] s;
      logic [31:0] t;
      int          kind;
      r    = $urandom;
      s    = $urandom;
      t    = $urandom;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: return {1'b1, r[30:0]};
         2:    return {1'b1, r[30:0] & s[30:0] & t[30:0]};   // sparse literal
         3:    return {1'b1, r[30:0] | s[30:0]};             // dense literal
         4:    return ($urandom_range(0, 15) == 0) ? {3'b000, r[28:0]}
                                                   : 32'($urandom_range(0, 300));
         5, 6: return {1'b0, FLAGS_LFL, r[28:0]};
         default: return {2'b01, r[29:0]};                     // FLF, both flag codes
      endcase
   endfunction

   task automatic test_random();
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         no_idle = (i % 90) >= 70;
         send_word(random_word(), ($urandom_range(0, 9) == 0));
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      errors     = 0;
      no_idle    = 1'b0;
      run_pos    = '0;
      ovf_seen   = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_literals();
      test_zero_fills();
      test_lfl();
      test_flf();
      test_overflow();
      test_random();
      req_tvalid <= 1'b0;

      // drain, then let trailing work settle
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
